// ===== design/route_two_opt_improve_assert.svh =====
// Assertion macros shared by the route improvement block.
`ifndef ROUTE_TWO_OPT_IMPROVE_ASSERT_SVH
`define ROUTE_TWO_OPT_IMPROVE_ASSERT_SVH
`ifndef SYNTHESIS
`define RTO_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`define RTO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTO_ASSERT_NEVER(label, clk, rst_n, expr)
`define RTO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/rto_pkg.sv =====
// Package with the command, status and state types of the route improvement block.
package rto_pkg;

    localparam int COST_W = 22;
    localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;
    localparam int FIELD_W = 6;
    localparam int DIST_IN_W = 16;

    typedef enum logic [5:0] {
        C_NOP, C_LOAD, C_I_INIT, C_J_NEXT, C_I_NEXT,
        C_RD_A, C_RD_B, C_RD_C, C_RD_D, C_CAP_D,
        C_DQ1, C_DQ2, C_DQ3, C_DQ4,
        C_REV_INIT, C_REV_R1, C_REV_R2, C_REV_W1, C_REV_W2,
        C_FIND_INIT, C_FIND_RD, C_FIND_CHK,
        C_CP_INIT, C_CP_RD, C_CP_WR,
        C_BK_INIT, C_BK_RD, C_BK_WR,
        C_EM_INIT, C_EM_PREV, C_EM_RD, C_EM_NODE, C_EM_DIST, C_EM_ACC
    } t_cmd;

    typedef enum logic [5:0] {
        S_IDLE, S_I_INIT, S_J_CHECK,
        S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_CAP_D,
        S_DQ1, S_DQ2, S_DQ3, S_DQ4, S_DECIDE,
        S_J_NEXT, S_I_NEXT,
        S_REV_INIT, S_REV_CHK, S_REV_R1, S_REV_R2, S_REV_W1, S_REV_W2,
        S_FIND_INIT, S_FIND_RD, S_FIND_CHK,
        S_CP_INIT, S_CP_RD, S_CP_WR,
        S_BK_INIT, S_BK_RD, S_BK_WR,
        S_EM_INIT, S_EM_PREV, S_EM_RD, S_EM_NODE, S_EM_DIST, S_EM_WAIT
    } t_state;

    typedef struct packed {
        logic j_done;
        logic i_last;
        logic neg;
        logic cnt_zero;
        logic is_zero;
        logic k_last;
    } t_status;

endpackage

// ===== design/rto_ram.sv =====
// Generic single write port RAM with one registered read port.
module rto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rto_dp.sv =====
// Datapath of the route improvement block: memories, loop counters and output item.
module rto_dp #(
    parameter int NODES = 64,
    parameter int ROUTE_MAX = 64,
    parameter int DIST_BITS = 16
) (
    input  logic                    i_clk,
    input  rto_pkg::t_cmd           i_cmd,
    input  logic                    i_op,
    input  logic [5:0]              i_from_node,
    input  logic [5:0]              i_to_node,
    input  logic [15:0]             i_distance,
    input  logic [5:0]              i_position,
    input  logic [5:0]              i_node,
    input  logic                    i_last,
    output rto_pkg::t_status        o_status,
    output logic [5:0]              o_out_position,
    output logic [5:0]              o_out_node,
    output logic [15:0]             o_edge_distance,
    output logic [21:0]             o_route_cost,
    output logic                    o_out_last
);
    import rto_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int DDEPTH = 1 << (2 * NW);
    localparam int RW = (ROUTE_MAX > 1) ? $clog2(ROUTE_MAX) : 1;
    localparam int TW = $clog2(ROUTE_MAX + 1);
    localparam int PW = (RW > FIELD_W) ? RW : FIELD_W;
    localparam int TX = (TW > 7) ? TW : 7;
    localparam int EW = (DIST_BITS > DIST_IN_W) ? DIST_BITS : DIST_IN_W;
    localparam int AW = DIST_BITS + 3;
    localparam int SUMW = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;

    logic [TW-1:0]         r_t, r_cnt;
    logic [RW-1:0]         r_i, r_im1, r_jm, r_j1m, r_p1, r_p2, r_k, r_q;
    logic [5:0]            r_a, r_b, r_c, r_d, r_x, r_prev, r_node;
    logic signed [AW-1:0]  r_acc;
    logic [COST_W-1:0]     r_cost;
    logic [5:0]            r_out_pos, r_out_node;
    logic [15:0]           r_out_edge;
    logic [COST_W-1:0]     r_out_cost;
    logic                  r_out_last;

    logic                  rt_we, tp_we, dt_we;
    logic [RW-1:0]         rt_waddr, rt_raddr;
    logic [5:0]            rt_wdata, rt_rdata, tp_rdata;
    logic [2*NW-1:0]       dt_waddr, dt_raddr;
    logic [DIST_BITS-1:0]  dt_wdata, dt_rdata;
    logic [RW-1:0]         tm1, pos_idx, im1_n, jm_n, j1m_n;
    logic [PW-1:0]         pos_ext, k_ext;
    logic [EW-1:0]         din_ext, e_ext;
    logic                  pos_ok;
    logic [TW-1:0]         t_load;
    logic [TX-1:0]         pos1_ext;
    logic [TW:0]           rev_len;
    logic signed [AW-1:0]  d_ext;
    logic [SUMW-1:0]       cost_sum;
    logic [COST_W-1:0]     cost_next;

    function automatic logic [NW-1:0] f_modn(input logic [5:0] v);
        logic [15:0] r;
        r = 16'(v);
        for (int b = 5; b >= 0; b--) begin
            if (r >= 16'(NODES << b)) begin
                r = r - 16'(NODES << b);
            end
        end
        return r[NW-1:0];
    endfunction

    function automatic logic [RW-1:0] f_inc(input logic [RW-1:0] x, input logic [TW-1:0] t);
        return (TW'(x) + TW'(1) == t) ? '0 : RW'(x + 1'b1);
    endfunction

    function automatic logic [RW-1:0] f_dec(input logic [RW-1:0] x, input logic [RW-1:0] tl);
        return (x == '0) ? tl : RW'(x - 1'b1);
    endfunction

    always_comb begin
        tm1 = RW'(r_t - TW'(1));
        pos_ext = PW'(i_position);
        pos_idx = pos_ext[RW-1:0];
        pos_ok = (32'(i_position) < ROUTE_MAX);
        pos1_ext = TX'(7'(i_position) + 7'd1);
        t_load = pos_ok ? pos1_ext[TW-1:0] : TW'(ROUTE_MAX);
        din_ext = EW'(i_distance);
        im1_n = f_inc(r_i, r_t);
        jm_n = f_inc(im1_n, r_t);
        j1m_n = f_inc(jm_n, r_t);
        rev_len = (r_im1 > r_jm) ? ((TW+1)'(r_t) - (TW+1)'(r_im1) + (TW+1)'(r_jm) + 1'b1)
                                 : ((TW+1)'(r_jm) - (TW+1)'(r_im1) + 1'b1);
        d_ext = AW'(signed'({3'b000, dt_rdata}));
        e_ext = EW'(dt_rdata);
        cost_sum = SUMW'(r_cost) + SUMW'(dt_rdata);
        cost_next = (cost_sum > SUMW'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];
        k_ext = PW'(r_k);
    end

    always_comb begin
        rt_we = 1'b0;
        rt_waddr = r_k;
        rt_wdata = tp_rdata;
        rt_raddr = r_i;
        tp_we = 1'b0;
        dt_we = 1'b0;
        dt_waddr = {f_modn(i_from_node), f_modn(i_to_node)};
        dt_wdata = din_ext[DIST_BITS-1:0];
        dt_raddr = {f_modn(r_a), f_modn(r_c)};
        unique case (i_cmd)
            C_LOAD: begin
                dt_we = !i_op;
                rt_we = i_op && pos_ok;
                rt_waddr = pos_idx;
                rt_wdata = i_node;
            end
            C_RD_A:    rt_raddr = r_i;
            C_RD_B:    rt_raddr = r_im1;
            C_RD_C:    rt_raddr = r_jm;
            C_RD_D:    rt_raddr = r_j1m;
            C_CAP_D:   dt_raddr = {f_modn(r_a), f_modn(r_c)};
            C_DQ1:     dt_raddr = {f_modn(r_b), f_modn(r_d)};
            C_DQ2:     dt_raddr = {f_modn(r_a), f_modn(r_b)};
            C_DQ3:     dt_raddr = {f_modn(r_c), f_modn(r_d)};
            C_REV_R1:  rt_raddr = r_p1;
            C_REV_R2:  rt_raddr = r_p2;
            C_REV_W1: begin
                rt_we = 1'b1;
                rt_waddr = r_p1;
                rt_wdata = rt_rdata;
            end
            C_REV_W2: begin
                rt_we = 1'b1;
                rt_waddr = r_p2;
                rt_wdata = r_x;
            end
            C_FIND_RD: rt_raddr = r_k;
            C_CP_RD:   rt_raddr = r_q;
            C_CP_WR:   tp_we = 1'b1;
            C_BK_WR: begin
                rt_we = 1'b1;
                rt_waddr = r_k;
                rt_wdata = tp_rdata;
            end
            C_EM_INIT: rt_raddr = tm1;
            C_EM_RD:   rt_raddr = r_k;
            C_EM_NODE: dt_raddr = {f_modn(r_prev), f_modn(rt_rdata)};
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            C_LOAD: begin
                r_i <= '0;
                if (i_op && i_last) begin
                    r_t <= t_load;
                end
            end
            C_I_INIT: begin
                r_im1 <= im1_n;
                r_jm <= jm_n;
                r_j1m <= j1m_n;
            end
            C_J_NEXT: begin
                r_jm <= r_j1m;
                r_j1m <= f_inc(r_j1m, r_t);
            end
            C_I_NEXT: r_i <= RW'(r_i + 1'b1);
            C_RD_B:   r_a <= rt_rdata;
            C_RD_C:   r_b <= rt_rdata;
            C_RD_D:   r_c <= rt_rdata;
            C_CAP_D:  r_d <= rt_rdata;
            C_DQ1:    r_acc <= d_ext;
            C_DQ2:    r_acc <= r_acc + d_ext;
            C_DQ3, C_DQ4: r_acc <= r_acc - d_ext;
            C_REV_INIT: begin
                r_p1 <= r_im1;
                r_p2 <= r_jm;
                r_cnt <= rev_len[TW:1];
            end
            C_REV_R2: r_x <= rt_rdata;
            C_REV_W2: begin
                r_p1 <= f_inc(r_p1, r_t);
                r_p2 <= f_dec(r_p2, tm1);
                r_cnt <= r_cnt - TW'(1);
            end
            C_FIND_INIT, C_CP_INIT, C_BK_INIT: r_k <= '0;
            C_FIND_CHK: begin
                r_q <= r_k;
                r_k <= RW'(r_k + 1'b1);
            end
            C_CP_WR: begin
                r_k <= RW'(r_k + 1'b1);
                r_q <= f_inc(r_q, r_t);
            end
            C_BK_WR: r_k <= RW'(r_k + 1'b1);
            C_EM_INIT: begin
                r_k <= '0;
                r_cost <= '0;
            end
            C_EM_PREV: r_prev <= rt_rdata;
            C_EM_NODE: r_node <= rt_rdata;
            C_EM_DIST: begin
                r_cost <= cost_next;
                r_out_pos <= k_ext[5:0];
                r_out_node <= r_node;
                r_out_edge <= e_ext[15:0];
                r_out_last <= o_status.k_last;
                r_out_cost <= o_status.k_last ? cost_next : '0;
            end
            C_EM_ACC: begin
                r_prev <= r_node;
                r_k <= RW'(r_k + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.j_done = (r_j1m == r_i);
        o_status.i_last = (TW'(r_i) + TW'(1) == r_t);
        o_status.neg = r_acc[AW-1];
        o_status.cnt_zero = (r_cnt == '0);
        o_status.is_zero = (rt_rdata == '0);
        o_status.k_last = (TW'(r_k) + TW'(1) == r_t);
    end

    rto_ram #(.WIDTH(FIELD_W), .DEPTH(ROUTE_MAX)) u_route (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(rt_wdata),
        .i_raddr(rt_raddr), .o_rdata(rt_rdata)
    );

    rto_ram #(.WIDTH(FIELD_W), .DEPTH(ROUTE_MAX)) u_temp (
        .i_clk(i_clk), .i_we(tp_we), .i_waddr(r_k), .i_wdata(rt_rdata),
        .i_raddr(r_k), .o_rdata(tp_rdata)
    );

    rto_ram #(.WIDTH(DIST_BITS), .DEPTH(DDEPTH)) u_dist (
        .i_clk(i_clk), .i_we(dt_we), .i_waddr(dt_waddr), .i_wdata(dt_wdata),
        .i_raddr(dt_raddr), .o_rdata(dt_rdata)
    );

    assign o_out_position = r_out_pos;
    assign o_out_node = r_out_node;
    assign o_edge_distance = r_out_edge;
    assign o_route_cost = r_out_cost;
    assign o_out_last = r_out_last;

endmodule

// ===== design/rto_ctrl.sv =====
// Controller state machine that sequences load, 2-opt pass, rotation and emission.
`include "route_two_opt_improve_assert.svh"
module rto_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_op,
    input  logic             i_last,
    input  logic             i_out_ready,
    input  rto_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output rto_pkg::t_cmd    o_cmd
);
    import rto_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = C_NOP;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = C_LOAD;
                    if (i_op && i_last) begin
                        n_state = S_I_INIT;
                    end
                end
            end
            S_I_INIT: begin
                o_cmd = C_I_INIT;
                n_state = S_J_CHECK;
            end
            S_J_CHECK: n_state = i_status.j_done ? S_I_NEXT : S_RD_A;
            S_RD_A: begin
                o_cmd = C_RD_A;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                o_cmd = C_RD_B;
                n_state = S_RD_C;
            end
            S_RD_C: begin
                o_cmd = C_RD_C;
                n_state = S_RD_D;
            end
            S_RD_D: begin
                o_cmd = C_RD_D;
                n_state = S_CAP_D;
            end
            S_CAP_D: begin
                o_cmd = C_CAP_D;
                n_state = S_DQ1;
            end
            S_DQ1: begin
                o_cmd = C_DQ1;
                n_state = S_DQ2;
            end
            S_DQ2: begin
                o_cmd = C_DQ2;
                n_state = S_DQ3;
            end
            S_DQ3: begin
                o_cmd = C_DQ3;
                n_state = S_DQ4;
            end
            S_DQ4: begin
                o_cmd = C_DQ4;
                n_state = S_DECIDE;
            end
            S_DECIDE: n_state = i_status.neg ? S_REV_INIT : S_J_NEXT;
            S_REV_INIT: begin
                o_cmd = C_REV_INIT;
                n_state = S_REV_CHK;
            end
            S_REV_CHK: n_state = i_status.cnt_zero ? S_J_NEXT : S_REV_R1;
            S_REV_R1: begin
                o_cmd = C_REV_R1;
                n_state = S_REV_R2;
            end
            S_REV_R2: begin
                o_cmd = C_REV_R2;
                n_state = S_REV_W1;
            end
            S_REV_W1: begin
                o_cmd = C_REV_W1;
                n_state = S_REV_W2;
            end
            S_REV_W2: begin
                o_cmd = C_REV_W2;
                n_state = S_REV_CHK;
            end
            S_J_NEXT: begin
                o_cmd = C_J_NEXT;
                n_state = S_J_CHECK;
            end
            S_I_NEXT: begin
                o_cmd = C_I_NEXT;
                n_state = i_status.i_last ? S_FIND_INIT : S_I_INIT;
            end
            S_FIND_INIT: begin
                o_cmd = C_FIND_INIT;
                n_state = S_FIND_RD;
            end
            S_FIND_RD: begin
                o_cmd = C_FIND_RD;
                n_state = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                o_cmd = C_FIND_CHK;
                priority if (i_status.is_zero) begin
                    n_state = S_CP_INIT;
                end else if (i_status.k_last) begin
                    n_state = S_EM_INIT;
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_CP_INIT: begin
                o_cmd = C_CP_INIT;
                n_state = S_CP_RD;
            end
            S_CP_RD: begin
                o_cmd = C_CP_RD;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd = C_CP_WR;
                n_state = i_status.k_last ? S_BK_INIT : S_CP_RD;
            end
            S_BK_INIT: begin
                o_cmd = C_BK_INIT;
                n_state = S_BK_RD;
            end
            S_BK_RD: begin
                o_cmd = C_BK_RD;
                n_state = S_BK_WR;
            end
            S_BK_WR: begin
                o_cmd = C_BK_WR;
                n_state = i_status.k_last ? S_EM_INIT : S_BK_RD;
            end
            S_EM_INIT: begin
                o_cmd = C_EM_INIT;
                n_state = S_EM_PREV;
            end
            S_EM_PREV: begin
                o_cmd = C_EM_PREV;
                n_state = S_EM_RD;
            end
            S_EM_RD: begin
                o_cmd = C_EM_RD;
                n_state = S_EM_NODE;
            end
            S_EM_NODE: begin
                o_cmd = C_EM_NODE;
                n_state = S_EM_DIST;
            end
            S_EM_DIST: begin
                o_cmd = C_EM_DIST;
                n_state = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd = C_EM_ACC;
                    n_state = i_status.k_last ? S_IDLE : S_EM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `RTO_ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, o_in_ready && o_out_valid)
    `RTO_ASSERT_NEXT(a_pass_starts, i_clk, i_rst_n, i_in_valid && o_in_ready && i_op && i_last, !o_in_ready)
    `RTO_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_out_valid && i_out_ready && i_status.k_last, o_in_ready)

endmodule

// ===== design/route_two_opt_improve.sv =====
// Top level of the first-improvement 2-opt route improvement block.
// Distance and route write items are taken back to back while the block is idle. A route
// item marked last starts a pass that runs until every result item has been taken; no item
// is accepted meanwhile. A pass over a route of t nodes tries t*(t-3) node pairs (t pairs
// for a two-node route), reading four route nodes and four distances for each pair, and
// reverses the segment by swapping node pairs when the swap shortens the route. It then
// rotates the depot to the front and emits one item per node while the output side is ready.
// Every step goes through the single read port of the route memory and of the distance memory.
module route_two_opt_improve #(
    parameter int NODES = 64,
    parameter int ROUTE_MAX = 64,
    parameter int DIST_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [5:0]  i_from_node,
    input  logic [5:0]  i_to_node,
    input  logic [15:0] i_distance,
    input  logic [5:0]  i_position,
    input  logic [5:0]  i_node,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_out_position,
    output logic [5:0]  o_out_node,
    output logic [15:0] o_edge_distance,
    output logic [21:0] o_route_cost,
    output logic        o_out_last
);
    import rto_pkg::*;

    t_cmd    cmd;
    t_status status;

    rto_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_op(i_op),
        .i_last(i_last), .i_out_ready(i_ready), .i_status(status),
        .o_in_ready(o_ready), .o_out_valid(o_valid), .o_cmd(cmd)
    );

    rto_dp #(.NODES(NODES), .ROUTE_MAX(ROUTE_MAX), .DIST_BITS(DIST_BITS)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_op(i_op), .i_from_node(i_from_node),
        .i_to_node(i_to_node), .i_distance(i_distance), .i_position(i_position),
        .i_node(i_node), .i_last(i_last), .o_status(status),
        .o_out_position(o_out_position), .o_out_node(o_out_node),
        .o_edge_distance(o_edge_distance), .o_route_cost(o_route_cost),
        .o_out_last(o_out_last)
    );

endmodule
